### rtl/core/beq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the button edge event queue
// no dependencies; compiled before every other file of the block

package beq_pkg;

	localparam int USER_W     = 2;
	localparam int PACKET_W   = 32;
	localparam int BUTTON_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int KEY_CODE_W = 15;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int NUM_SCAN = 12;
	localparam int SLOT_W   = 4;

	localparam logic [BUTTON_W-1:0] MASK_RESET = 16'hE0C0;

	localparam logic [STATUS_W-1:0] ST_EVENT       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_HANDLED = 2'd2;

	localparam logic [KEY_CODE_W-1:0] KEY_DPAD_UP = 15'h5810;
	localparam logic [KEY_CODE_W-1:0] KEY_A       = 15'h5800;

	typedef struct packed {
		logic              down;
		logic [SLOT_W-1:0] slot;
	} event_t;

	typedef struct packed {
		logic   push;
		event_t push_ev;
		logic   pop;
	} ring_ctl_t;

	typedef struct packed {
		logic   empty;
		event_t rd_ev;
	} ring_stat_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	// dpad, start, back and thumbs map to 0x5810.., face buttons to 0x5800..
	function automatic logic [KEY_CODE_W-1:0] key_code_of(input logic [SLOT_W-1:0] slot);
		case (slot) inside
			[4'd0:4'd7]:  return KEY_DPAD_UP + KEY_CODE_W'(slot[2:0]);
			[4'd8:4'd11]: return KEY_A + KEY_CODE_W'(slot[1:0]);
			default:      return '0;
		endcase
	endfunction

endpackage

### rtl/core/beq_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the button edge event queue: poll in, event out
// depends on beq_pkg for field widths

interface beq_poll_if;
	logic                              valid;
	logic                              ready;
	logic [beq_pkg::USER_W-1:0]        user_index;
	logic                              source_connected;
	logic [beq_pkg::PACKET_W-1:0]      packet_number;
	logic [beq_pkg::BUTTON_W-1:0]      button_word;

	modport source (output valid, user_index, source_connected, packet_number,
		button_word, input ready);
	modport sink (input valid, user_index, source_connected, packet_number,
		button_word, output ready);
endinterface

interface beq_event_if;
	logic                              valid;
	logic                              ready;
	logic [beq_pkg::STATUS_W-1:0]      status;
	logic [beq_pkg::KEY_CODE_W-1:0]    key_code;
	logic                              key_down;

	modport source (output valid, status, key_code, key_down, input ready);
	modport sink (input valid, status, key_code, key_down, output ready);
endinterface

### rtl/core/button_edge_event_queue.sv
`timescale 1ns / 1ps
// top level of the button edge event queue: poll sequencer, serial scan, output register
// depends on beq_pkg, beq_if and beq_ring
//
// usage
//   poll (sink): one beat per controller poll with user_index, source_connected,
//   packet_number and button_word. evt (source): exactly one beat per poll with
//   status (event, empty, not handled), key_code and key_down.
//   cfg_we/cfg_wdata write button_mask; write it only while the block is idle.
// timing
//   one poll is worked on at a time; poll.ready is high only in the idle state.
//   not served poll: idle, then S_RESP. served poll, same packet number: S_POP,
//   then S_RESP. served poll with a new packet number: S_SCAN, the serial change
//   scan that shifts one button per cycle through 12 positions and pushes at
//   most one event per cycle into the ring's single write port, then S_POP for
//   the registered ring read and S_RESP.
//   the result sits in an output register; the next poll is taken while it
//   waits. a stalled receiver holds the result and blocks only the next result.
// reset
//   arst_n clears the ring pointers, previous buttons and packet number, sets
//   button_mask to 0xE0C0. ring contents need no clearing.

module button_edge_event_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [beq_pkg::BUTTON_W-1:0]  cfg_wdata,
	beq_poll_if.sink                      poll,
	beq_event_if.source                   evt
);
	import beq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_POP  = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [BUTTON_W-1:0]    mask_q;
	logic [BUTTON_W-1:0]    prev_buttons_q;
	logic [PACKET_W-1:0]    prev_packet_q;
	logic [NUM_SCAN-1:0]    chg_sr_q;
	logic [NUM_SCAN-1:0]    lvl_sr_q;
	logic [SLOT_W-1:0]      cnt_q;
	logic [STATUS_W-1:0]    st_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [KEY_CODE_W-1:0]  out_code_q;
	logic                   out_down_q;

	logic                   accept;
	logic                   served;
	logic                   load_out;
	logic [BUTTON_W-1:0]    cur;
	logic [BUTTON_W-1:0]    chg;
	ring_ctl_t              ring_ctl;
	ring_stat_t             ring_stat;

	assign poll.ready = (state_q == S_IDLE);
	assign accept     = poll.valid && poll.ready;
	assign served     = (poll.user_index == '0) && poll.source_connected;
	assign cur        = poll.button_word & ~mask_q;
	assign chg        = cur ^ prev_buttons_q;
	assign load_out   = (state_q == S_RESP) && (!out_valid_q || evt.ready);

	assign ring_ctl.push    = (state_q == S_SCAN) && chg_sr_q[0];
	assign ring_ctl.push_ev = '{down: lvl_sr_q[0], slot: cnt_q};
	assign ring_ctl.pop     = (state_q == S_POP);

	beq_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.stat   (ring_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_buttons_q <= '0;
			prev_packet_q  <= '0;
			cnt_q          <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!served) begin
							state_q <= S_RESP;
						end else if (poll.packet_number != prev_packet_q) begin
							prev_buttons_q <= cur;
							prev_packet_q  <= poll.packet_number;
							cnt_q          <= '0;
							state_q        <= S_SCAN;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_W'(NUM_SCAN - 1))
						state_q <= S_POP;
				end
				S_POP: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan order: bits 0..7 then 12..15; bits 8..11 are only remembered
	always_ff @(posedge clk) begin
		if (accept) begin
			chg_sr_q <= {chg[15:12], chg[7:0]};
			lvl_sr_q <= {cur[15:12], cur[7:0]};
			st_q     <= ST_NOT_HANDLED;
		end else if (state_q == S_SCAN) begin
			chg_sr_q <= {1'b0, chg_sr_q[NUM_SCAN-1:1]};
			lvl_sr_q <= {1'b0, lvl_sr_q[NUM_SCAN-1:1]};
		end else if (state_q == S_POP) begin
			st_q <= ring_stat.empty ? ST_EMPTY : ST_EVENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= st_q;
			if (st_q == ST_EVENT) begin
				out_code_q <= key_code_of(ring_stat.rd_ev.slot);
				out_down_q <= ring_stat.rd_ev.down;
			end else begin
				out_code_q <= '0;
				out_down_q <= 1'b0;
			end
		end
	end

	assign evt.valid    = out_valid_q;
	assign evt.status   = out_status_q;
	assign evt.key_code = out_code_q;
	assign evt.key_down = out_down_q;

`ifndef SYNTHESIS
	a_one_poll_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !poll.ready)
		else $error("poll taken while previous poll still in work");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q < SLOT_W'(NUM_SCAN))
		else $error("scan counter past last button");

	a_no_event_payload: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && st_q != ST_EVENT |=> evt.key_code == '0 && !evt.key_down)
		else $error("non-event result carries a key");
`endif

endmodule

### rtl/core/beq_ring.sv
`timescale 1ns / 1ps
// event ring: circular buffer with overwrite of the oldest entry when full
// depends on beq_pkg

module beq_ring (
	input  logic                clk,
	input  logic                arst_n,
	input  beq_pkg::ring_ctl_t  ctl,
	output beq_pkg::ring_stat_t stat
);
	import beq_pkg::*;

	event_t           mem [QUEUE_DEPTH];
	event_t           rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] tail_nxt;
	logic [PTR_W-1:0] head_nxt;
	logic             empty;
	logic             full;

	assign tail_nxt = ptr_next(tail_q);
	assign head_nxt = ptr_next(head_q);
	assign empty    = (head_q == tail_q);
	assign full     = (tail_nxt == head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_nxt;
				// full ring drops its oldest event
				if (full)
					head_q <= head_nxt;
			end else if (ctl.pop && !empty) begin
				head_q <= head_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[tail_q] <= ctl.push_ev;
		if (ctl.pop)
			rd_q <= mem[head_q];
	end

	assign stat.empty = empty;
	assign stat.rd_ev = rd_q;

`ifndef SYNTHESIS
	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> !empty)
		else $error("ring empty right after a push");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop && !ctl.push && !empty |=> head_q == $past(head_nxt))
		else $error("head did not advance on pop");

	a_full_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push && full |=> head_q == $past(head_nxt) && full)
		else $error("push into full ring did not drop oldest event");
`endif

endmodule

### sim/tb_button_edge_event_queue.sv
`timescale 1ns / 1ps
// testbench of button_edge_event_queue: directed and random polls, random stalls on both channels
// a scoreboard class predicts every event beat; depends on beq_pkg, beq_if and the block's rtl

module tb_button_edge_event_queue;
	import beq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [STATUS_W-1:0]   status;
		logic [KEY_CODE_W-1:0] key_code;
		logic                  key_down;
	} key_event_t;

	// predicts the key events of each poll and holds them until they come out
	class key_event_book;
		logic [BUTTON_W-1:0] mask;
		logic [BUTTON_W-1:0] last_buttons;
		logic [PACKET_W-1:0] last_packet;
		logic [SLOT_W:0]     ring [QUEUE_DEPTH];
		int                  head;
		int                  tail;
		key_event_t          waiting_q [$];
		int                  errors;

		function new();
			mask = MASK_RESET;
			last_buttons = '0;
			last_packet = '0;
			head = 0;
			tail = 0;
			errors = 0;
		endfunction

		function int wrap(int p);
			return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
		endfunction

		function int pending();
			return waiting_q.size();
		endfunction

		function void note_poll(logic [USER_W-1:0] user, logic conn,
				logic [PACKET_W-1:0] pkt, logic [BUTTON_W-1:0] word);
			key_event_t          ev;
			logic [BUTTON_W-1:0] cur;
			logic [BUTTON_W-1:0] diff;
			logic [SLOT_W:0]     entry;
			int                  b;
			ev = '{ST_NOT_HANDLED, '0, 1'b0};
			if (user == '0 && conn) begin
				if (pkt != last_packet) begin
					cur = word & ~mask;
					diff = cur ^ last_buttons;
					// dpad..thumbs sit in bits 0..7, face buttons in bits 12..15
					for (int s = 0; s < NUM_SCAN; s++) begin
						b = (s < 8) ? s : s + 4;
						if (diff[b]) begin
							// a full ring loses its oldest event
							if (wrap(tail) == head)
								head = wrap(head);
							ring[tail] = {cur[b], SLOT_W'(s)};
							tail = wrap(tail);
						end
					end
					last_buttons = cur;
					last_packet = pkt;
				end
				if (head == tail) begin
					ev = '{ST_EMPTY, '0, 1'b0};
				end else begin
					entry = ring[head];
					head = wrap(head);
					ev.status = ST_EVENT;
					ev.key_code = (entry[SLOT_W-1:0] < 8) ?
						KEY_DPAD_UP + KEY_CODE_W'(entry[SLOT_W-1:0]) :
						KEY_A + KEY_CODE_W'(entry[SLOT_W-1:0] - 8);
					ev.key_down = entry[SLOT_W];
				end
			end
			waiting_q.push_back(ev);
		endfunction

		function void check_event(key_event_t got);
			key_event_t want;
			if (waiting_q.size() == 0) begin
				$error("event beat with no poll waiting for it");
				errors++;
				return;
			end
			want = waiting_q.pop_front();
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
			if (got.key_code !== want.key_code) begin
				$error("key_code expected %h actual %h", want.key_code, got.key_code);
				errors++;
			end
			if (got.key_down !== want.key_down) begin
				$error("key_down expected %b actual %b", want.key_down, got.key_down);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [BUTTON_W-1:0] cfg_wdata;

	beq_poll_if  poll_ch ();
	beq_event_if evt_ch ();

	button_edge_event_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.poll      (poll_ch),
		.evt       (evt_ch)
	);

	key_event_book       book = new();
	int unsigned         cycles = 0;
	int                  polls_sent = 0;
	int                  events_seen = 0;
	logic [PACKET_W-1:0] last_pkt = '0;
	logic [BUTTON_W-1:0] last_word = '0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_button_edge_event_queue NOT OK");
			$finish;
		end
	end

	// stretches of back-to-back beats between randomly idled ones
	function automatic int idle_cycles(int n);
		return (n % 128 < 24) ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic send_poll(input logic [USER_W-1:0] user, input logic conn,
			input logic [PACKET_W-1:0] pkt, input logic [BUTTON_W-1:0] word,
			input bit drain);
		int gap;
		gap = idle_cycles(polls_sent);
		if (drain || gap > 0) begin
			poll_ch.valid <= 1'b0;
			if (drain)
				while (book.pending() != 0) @(posedge clk);
			repeat (drain ? gap + 1 : gap) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.user_index <= user;
		poll_ch.source_connected <= conn;
		poll_ch.packet_number <= pkt;
		poll_ch.button_word <= word;
		do @(posedge clk); while (!poll_ch.ready);
		book.note_poll(user, conn, pkt, word);
		polls_sent++;
		last_pkt = pkt;
		last_word = word;
	endtask

	task automatic set_mask(input logic [BUTTON_W-1:0] value);
		poll_ch.valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.mask = value;
	endtask

	task automatic random_poll();
		logic [USER_W-1:0]   user;
		logic                conn;
		logic [PACKET_W-1:0] pkt;
		logic [BUTTON_W-1:0] word;
		int                  r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			user = USER_W'($urandom_range(1, 3));
			conn = 1'($urandom);
		end else if (r < 18) begin
			user = '0;
			conn = 1'b0;
		end else begin
			user = '0;
			conn = 1'b1;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			pkt = last_pkt + 1'b1;
		else if (r < 80)
			pkt = last_pkt;
		else if (r < 93)
			pkt = $urandom;
		else
			pkt = '0;
		r = $urandom_range(0, 99);
		if (r < 50)
			word = last_word ^ (BUTTON_W'(1) << $urandom_range(0, 15));
		else if (r < 75)
			word = last_word ^ BUTTON_W'($urandom & $urandom);
		else if (r < 90)
			word = BUTTON_W'($urandom);
		else
			word = ($urandom_range(0, 1) != 0) ? '1 : '0;
		send_poll(user, conn, pkt, word, $urandom_range(0, 59) == 0);
	endtask

	always begin
		int w;
		w = idle_cycles(events_seen);
		if (w > 0) begin
			evt_ch.ready <= 1'b0;
			repeat (w) @(posedge clk);
		end
		evt_ch.ready <= 1'b1;
		do @(posedge clk); while (!evt_ch.valid);
		book.check_event('{evt_ch.status, evt_ch.key_code, evt_ch.key_down});
		events_seen++;
	end

	initial begin
		logic [BUTTON_W-1:0] phase_mask [6];
		int                  phase_len;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.user_index <= '0;
		poll_ch.source_connected <= 1'b0;
		poll_ch.packet_number <= '0;
		poll_ch.button_word <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mask: packet 0 matches the cleared packet number, so no scan
		send_poll(2'd0, 1'b1, 32'h0, 16'hFFFF, 1'b0);
		send_poll(2'd1, 1'b1, 32'h1, 16'hFFFF, 1'b0);
		send_poll(2'd2, 1'b1, 32'h1, 16'hFFFF, 1'b0);
		send_poll(2'd3, 1'b1, 32'h1, 16'hFFFF, 1'b0);
		send_poll(2'd0, 1'b0, 32'h5, 16'hFFFF, 1'b0);
		send_poll(2'd0, 1'b1, 32'h1, 16'hFFFF, 1'b0);
		send_poll(2'd0, 1'b1, 32'h1, 16'h0000, 1'b0);
		send_poll(2'd0, 1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send_poll(2'd0, 1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b0);

		// nothing masked: three full toggles overrun the ring
		set_mask(16'h0000);
		send_poll(2'd0, 1'b1, 32'h2, 16'hFFFF, 1'b0);
		send_poll(2'd0, 1'b1, 32'h3, 16'h0000, 1'b0);
		send_poll(2'd0, 1'b1, 32'h4, 16'hFFFF, 1'b0);
		// only the unscanned bits 8..11 change
		send_poll(2'd0, 1'b1, 32'h5, 16'hF0FF, 1'b0);
		repeat (6) send_poll(2'd0, 1'b1, 32'h5, 16'h0000, 1'b0);

		set_mask(16'hFFFF);
		send_poll(2'd0, 1'b1, 32'h6, 16'h0000, 1'b0);
		send_poll(2'd0, 1'b1, 32'h7, 16'hFFFF, 1'b0);
		send_poll(2'd0, 1'b1, 32'h7, 16'hFFFF, 1'b0);

		phase_mask = '{16'h0000, BUTTON_W'($urandom), 16'hFFFF, MASK_RESET,
			BUTTON_W'($urandom), 16'h0F0F};
		for (int p = 0; p < 6; p++) begin
			set_mask(phase_mask[p]);
			phase_len = (phase_mask[p] == 16'hFFFF) ? 100 : 190;
			repeat (phase_len) random_poll();
		end

		poll_ch.valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (book.errors == 0)
			$display("tb_button_edge_event_queue OK");
		else
			$display("tb_button_edge_event_queue NOT OK");
		$finish;
	end

endmodule
